FILE: rtl/core/barker13_bpsk_sample_generator_top_assert.svh
// Assertion macros for the Barker-13 BPSK sample generator top level.
// Both macros expect clk and arst_n in scope.
`ifndef BARKER13_BPSK_SAMPLE_GENERATOR_TOP_ASSERT_SVH
`define BARKER13_BPSK_SAMPLE_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define B13_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define B13_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/b13_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b13_pkg
// Widths, register codes, stage payload types and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package b13_pkg;

	localparam int CODE_LENGTH = 13;
	localparam int SINE_DEPTH  = 1024;
	localparam int ADDR_W      = $clog2(SINE_DEPTH);
	localparam int QUARTER     = SINE_DEPTH / 4;
	localparam int QIDX_W      = ADDR_W - 2;

	localparam int IDX_W   = 24;
	localparam int STEP_W  = 32;
	localparam int CP_W    = 16;
	localparam int AMP_W   = 16;
	localparam int VAL_W   = 16;
	localparam int CHIP_W  = 4;
	localparam int CYC_W   = IDX_W + STEP_W;
	localparam int FRAC_W  = 32;
	localparam int WHOLE_W = CYC_W - FRAC_W;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [CHIP_W-1:0] CHIP_PAST = CHIP_W'(CODE_LENGTH);

	// Chips with a negative sign: + + + + + - - + + - + - +
	localparam logic [CODE_LENGTH-1:0] BARKER_NEG = 13'b0101001100000;

	localparam logic [STEP_W-1:0]       STEP_RST = 32'd429496730;
	localparam logic [CP_W-1:0]         CP_RST   = 16'd1;
	localparam logic signed [AMP_W-1:0] AMP_RST  = 16'sd16384;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CARRIER_STEP = 2'd0,
		CFG_CHIP_PERIODS = 2'd1,
		CFG_AMPLITUDE    = 2'd2
	} cfg_reg_e;

	// Stage payloads
	typedef struct packed {
		logic [CYC_W-1:0] cyc;
	} phase_t;

	typedef struct packed {
		logic [CHIP_W-1:0] chip;
		logic              inb;
		logic              neg;
		logic              quad_neg;
		logic              peak;
		logic [QIDX_W-1:0] qidx;
	} chip_info_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] rom;
		logic [CHIP_W-1:0]       chip;
		logic                    inb;
		logic                    neg;
	} sine_t;

	typedef struct packed {
		logic signed [2*VAL_W-1:0] prod;
		logic [CHIP_W-1:0]         chip;
		logic                      inb;
		logic                      neg;
	} prod_t;

	typedef logic [VAL_W-1:0] qsine_tab_t [QUARTER];

	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

	// Sine of quarter-table entry j in Q15, integer Taylor series in Q30.
	function automatic logic [VAL_W-1:0] qsine(input int j);
		logic [63:0] x;
		logic [63:0] theta;
		logic [63:0] th2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] q15;
		x     = 64'(j) << (32 - ADDR_W);
		theta = (x * TWO_PI_Q30) >> 32;
		th2   = (theta * theta) >> 30;
		term  = theta;
		sum   = theta;
		term  = ((term * th2) >> 30) / 64'd6;
		sum   = (sum >= term) ? sum - term : 64'd0;
		term  = ((term * th2) >> 30) / 64'd20;
		sum   = sum + term;
		term  = ((term * th2) >> 30) / 64'd42;
		sum   = (sum >= term) ? sum - term : 64'd0;
		term  = ((term * th2) >> 30) / 64'd72;
		sum   = sum + term;
		term  = ((term * th2) >> 30) / 64'd110;
		sum   = (sum >= term) ? sum - term : 64'd0;
		term  = ((term * th2) >> 30) / 64'd156;
		sum   = sum + term;
		q15   = (sum + 64'd16384) >> 15;
		if (q15 > 64'd32767) begin
			q15 = 64'd32767;
		end
		return q15[VAL_W-1:0];
	endfunction

	function automatic qsine_tab_t build_qsine();
		qsine_tab_t tab;
		for (int j = 0; j < QUARTER; j++) begin
			tab[j] = qsine(j);
		end
		return tab;
	endfunction

	localparam qsine_tab_t       QSINE      = build_qsine();
	localparam logic [VAL_W-1:0] QSINE_PEAK = qsine(QUARTER);

endpackage

FILE: rtl/core/b13_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b13_if
// Request channels: sample index in, modulated sample out.
// ----------------------------------------------------------------------------
interface b13_in_if import b13_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] sample_index;

	modport source (output valid, output sample_index, input ready);
	modport sink   (input valid, input sample_index, output ready);
endinterface

interface b13_out_if import b13_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] sample_value;
	logic [CHIP_W-1:0]       chip_number;
	logic                    in_burst;

	modport source (output valid, output sample_value, output chip_number, output in_burst,
		input ready);
	modport sink   (input valid, input sample_value, input chip_number, input in_burst,
		output ready);
endinterface

FILE: rtl/core/b13_phase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b13_phase
// Stage 1: elapsed carrier cycles, sample index times carrier step (Q32).
// ----------------------------------------------------------------------------
module b13_phase import b13_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_in,
	input  logic [IDX_W-1:0]  idx,
	input  logic [STEP_W-1:0] step,
	output logic              vld_s1,
	output phase_t            ph_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s1.cyc <= CYC_W'(idx) * CYC_W'(step);
		end
	end

endmodule

FILE: rtl/core/b13_chip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b13_chip
// Stage 2: chip number by compare against chip boundaries, burst flag and
// folded sine table address.
// ----------------------------------------------------------------------------
module b13_chip import b13_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_in,
	input  phase_t          ph,
	input  logic [CP_W-1:0] chip_periods,
	output logic            vld_s2,
	output chip_info_t      info_s2
);

	logic [WHOLE_W-1:0]     whole;
	logic [FRAC_W-1:0]      frac;
	logic [CP_W-1:0]        cp_eff;
	logic [WHOLE_W-1:0]     bound [CODE_LENGTH];
	logic [CODE_LENGTH-1:0] ge;
	logic [CHIP_W-1:0]      chip_c;
	logic [ADDR_W-1:0]      addr;
	logic [1:0]             quad;
	logic [QIDX_W-1:0]      j;
	chip_info_t             info_c;

	assign whole  = ph.cyc[CYC_W-1:FRAC_W];
	assign frac   = ph.cyc[FRAC_W-1:0];
	assign cp_eff = (chip_periods == '0) ? CP_W'(1) : chip_periods;

	// Thermometer of chip boundaries k * chip_periods, k = 1 .. 13
	always_comb begin
		for (int k = 0; k < CODE_LENGTH; k++) begin
			bound[k] = WHOLE_W'(cp_eff) * WHOLE_W'(k + 1);
			ge[k]    = whole >= bound[k];
		end
	end

	assign chip_c = CHIP_W'($countones(ge));
	assign addr   = frac[FRAC_W-1 -: ADDR_W];
	assign quad   = addr[ADDR_W-1 -: 2];
	assign j      = addr[QIDX_W-1:0];

	always_comb begin
		info_c.chip     = chip_c;
		// end boundary counts as inside the burst
		info_c.inb      = (whole < bound[CODE_LENGTH-1]) ||
			((whole == bound[CODE_LENGTH-1]) && (frac == '0));
		info_c.neg      = (chip_c < CHIP_PAST) ? BARKER_NEG[chip_c] : 1'b0;
		info_c.quad_neg = quad[1];
		// mirrored quadrant: entry QUARTER - j, the crest when j is zero
		info_c.peak     = quad[0] && (j == '0);
		info_c.qidx     = quad[0] ? (~j + QIDX_W'(1)) : j;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			info_s2 <= info_c;
		end
	end

endmodule

FILE: rtl/core/b13_sine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b13_sine
// Stage 3: quarter-wave sine lookup with quadrant sign.
// ----------------------------------------------------------------------------
module b13_sine import b13_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       vld_in,
	input  chip_info_t info,
	output logic       vld_s3,
	output sine_t      sine_s3
);

	logic [VAL_W-1:0] mag;
	sine_t            sine_c;

	assign mag = info.peak ? QSINE_PEAK : QSINE[info.qidx];

	always_comb begin
		sine_c.rom  = info.quad_neg ? -$signed(mag) : $signed(mag);
		sine_c.chip = info.chip;
		sine_c.inb  = info.inb;
		sine_c.neg  = info.neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sine_s3 <= sine_c;
		end
	end

endmodule

FILE: rtl/core/b13_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b13_scale
// Stages 4 and 5: amplitude multiply, then Q15 shift, saturation and chip
// sign into the output register, with zero past the code.
// ----------------------------------------------------------------------------
module b13_scale import b13_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en4,
	input  logic                    en5,
	input  logic                    vld_in,
	input  sine_t                   sine,
	input  logic signed [AMP_W-1:0] amplitude,
	output logic                    vld_s4,
	output logic                    vld_s5,
	output logic signed [VAL_W-1:0] value_s5,
	output logic [CHIP_W-1:0]       chip_s5,
	output logic                    inb_s5
);

	localparam logic signed [VAL_W:0] SAT_POS = 17'sd32767;

	prod_t                   prod_s4;
	logic signed [VAL_W:0]   shifted;
	logic signed [VAL_W-1:0] sat1;
	logic signed [VAL_W:0]   negated;
	logic signed [VAL_W-1:0] sat2;
	logic signed [VAL_W-1:0] value_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en4) begin
				vld_s4 <= vld_in;
			end
			if (en5) begin
				vld_s5 <= vld_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			prod_s4.prod <= amplitude * sine.rom;
			prod_s4.chip <= sine.chip;
			prod_s4.inb  <= sine.inb;
			prod_s4.neg  <= sine.neg;
		end
	end

	// floor(prod / 2^15); only full-scale negative squared overflows upward
	assign shifted = $signed(prod_s4.prod[2*VAL_W-1:VAL_W-1]);
	assign sat1    = (shifted > SAT_POS) ? VAL_W'(SAT_POS) : shifted[VAL_W-1:0];
	assign negated = -{sat1[VAL_W-1], sat1};
	assign sat2    = (negated > SAT_POS) ? VAL_W'(SAT_POS) : negated[VAL_W-1:0];

	always_comb begin
		if (prod_s4.chip >= CHIP_PAST) begin
			value_c = '0;
		end else if (prod_s4.neg) begin
			value_c = sat2;
		end else begin
			value_c = sat1;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			value_s5 <= value_c;
			chip_s5  <= prod_s4.chip;
			inb_s5   <= prod_s4.inb;
		end
	end

endmodule

FILE: rtl/core/barker13_bpsk_sample_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barker13_bpsk_sample_generator_top
// Barker-13 BPSK carrier sample generator, one sample per unstalled clock.
//
// sample_in carries a sample index; sample_out returns the modulated sample,
// the chip number (13 past the code) and the in-burst flag, one request out
// for every request in, in order. carrier_step, chip_periods and amplitude
// are set through the cfg_we / cfg_index / cfg_wdata write port, which the
// user must write only while idle; the block does not enforce it. Five
// register stages: phase multiply, chip decode, sine lookup, amplitude
// multiply, saturate/sign into the output register, which drives sample_out.
// One request is taken every cycle while the pipeline is not stalled.
// Each stage holds its request only while the stage after it is full and
// stalled, so bubbles close up and sample_in stays ready while sample_out
// waits until all five stages are full. Reset empties the pipeline and loads
// the register defaults; the sine table is constant and needs no fill.
// ----------------------------------------------------------------------------
module barker13_bpsk_sample_generator_top import b13_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	b13_in_if.sink               sample_in,
	b13_out_if.source            sample_out
);

	logic [STEP_W-1:0]       step_q;
	logic [CP_W-1:0]         cp_q;
	logic signed [AMP_W-1:0] amp_q;

	logic       vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic       en1, en2, en3, en4, en5;
	phase_t     ph_s1;
	chip_info_t info_s2;
	sine_t      sine_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RST;
			cp_q   <= CP_RST;
			amp_q  <= AMP_RST;
		end else if (cfg_we) begin
			case (cfg_reg_e'(cfg_index))
				CFG_CARRIER_STEP: step_q <= cfg_wdata[STEP_W-1:0];
				CFG_CHIP_PERIODS: cp_q   <= cfg_wdata[CP_W-1:0];
				CFG_AMPLITUDE:    amp_q  <= $signed(cfg_wdata[AMP_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	// advance a stage when it is empty or the next one advances
	assign en5 = !vld_s5 || sample_out.ready;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;

	assign sample_in.ready  = en1;
	assign sample_out.valid = vld_s5;

	b13_phase u_phase (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en1),
		.vld_in (sample_in.valid),
		.idx    (sample_in.sample_index),
		.step   (step_q),
		.vld_s1 (vld_s1),
		.ph_s1  (ph_s1)
	);

	b13_chip u_chip (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en2),
		.vld_in       (vld_s1),
		.ph           (ph_s1),
		.chip_periods (cp_q),
		.vld_s2       (vld_s2),
		.info_s2      (info_s2)
	);

	b13_sine u_sine (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en3),
		.vld_in  (vld_s2),
		.info    (info_s2),
		.vld_s3  (vld_s3),
		.sine_s3 (sine_s3)
	);

	b13_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en4       (en4),
		.en5       (en5),
		.vld_in    (vld_s3),
		.sine      (sine_s3),
		.amplitude (amp_q),
		.vld_s4    (vld_s4),
		.vld_s5    (vld_s5),
		.value_s5  (sample_out.sample_value),
		.chip_s5   (sample_out.chip_number),
		.inb_s5    (sample_out.in_burst)
	);

`include "barker13_bpsk_sample_generator_top_assert.svh"

	`B13_ASSERT_NOW(a_past_code_zero, sample_out.valid && sample_out.chip_number == CHIP_PAST, sample_out.sample_value == '0, "nonzero sample past the code")
	`B13_ASSERT_NOW(a_out_burst_past, sample_out.valid && !sample_out.in_burst, sample_out.chip_number == CHIP_PAST, "outside burst but chip inside code")
	`B13_ASSERT_NEXT(a_accept_enters, sample_in.valid && sample_in.ready, vld_s1, "accepted request not in stage 1")
	`B13_ASSERT_NEXT(a_s4_holds, vld_s4 && !en4, vld_s4, "stalled stage 4 request lost")

endmodule

FILE: tb/sv/tb_barker13_bpsk_sample_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_barker13_bpsk_sample_generator_top
// Drives sample indexes through the Barker-13 BPSK generator under several
// carrier, chip-length and amplitude settings, with random gaps on both
// channels, and checks every returned sample against a local prediction.
// ----------------------------------------------------------------------------
module tb_barker13_bpsk_sample_generator_top;
	import b13_pkg::*;

	localparam int          SINE_LEN     = 1024;
	localparam int          CHIPS        = 13;
	localparam logic [12:0] CHIP_FLIP    = 13'b0101001100000;
	localparam logic [63:0] TURN_Q30     = 64'd6746518852;
	localparam int          STALL_LIMIT  = 2000;
	localparam int          RANDOM_ITEMS = 125;

	// Expected samples, one per accepted index, in order.
	class sample_board;
		typedef struct {
			logic signed [15:0] value;
			logic [3:0]         chip;
			logic               burst;
		} sample_t;

		logic [31:0]        step;
		logic [15:0]        periods;
		logic signed [15:0] amp;
		int                 sine_tab [SINE_LEN];
		sample_t            expected_q [$];
		int                 failures;

		function new();
			logic [31:0] ph;
			logic [63:0] x;
			int          s;
			step     = STEP_RST;
			periods  = CP_RST;
			amp      = AMP_RST;
			failures = 0;
			for (int k = 0; k < SINE_LEN; k++) begin
				ph = 32'((64'(k) << 32) / SINE_LEN);
				x  = ph[30] ? (64'h4000_0000 - 64'(ph[29:0])) : 64'(ph[29:0]);
				s  = quarter_sine(x);
				sine_tab[k] = ph[31] ? -s : s;
			end
		endfunction

		// Taylor series of sin in Q30 over one quarter turn, rounded to Q15.
		function int quarter_sine(logic [63:0] x);
			logic [63:0] theta;
			logic [63:0] th2;
			logic [63:0] term;
			logic [63:0] sum;
			logic [63:0] q15;
			theta = (x * TURN_Q30) >> 32;
			th2   = (theta * theta) >> 30;
			term  = theta;
			sum   = theta;
			for (int n = 1; n <= 6; n++) begin
				term = ((term * th2) >> 30) / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					sum = (sum >= term) ? sum - term : 64'd0;
				end else begin
					sum = sum + term;
				end
			end
			q15 = (sum + 64'd16384) >> 15;
			if (q15 > 64'd32767) begin
				q15 = 64'd32767;
			end
			return int'(q15);
		endfunction

		function int clamp16(int v);
			if (v > 32767) begin
				return 32767;
			end
			if (v < -32768) begin
				return -32768;
			end
			return v;
		endfunction

		function void set_reg(cfg_reg_e r, logic [31:0] v);
			case (r)
				CFG_CARRIER_STEP: step = v;
				CFG_CHIP_PERIODS: periods = v[15:0];
				CFG_AMPLITUDE:    amp = v[15:0];
				default: ;
			endcase
		endfunction

		function void note_index(logic [23:0] idx);
			logic [55:0] cyc;
			logic [23:0] whole;
			logic [31:0] frac;
			logic [15:0] cp_eff;
			logic [23:0] chip;
			logic [63:0] burst_end;
			int          prod;
			int          scaled;
			sample_t     e;
			cyc       = 56'(idx) * 56'(step);
			whole     = cyc[55:32];
			frac      = cyc[31:0];
			cp_eff    = (periods == 16'd0) ? 16'd1 : periods;
			chip      = whole / 24'(cp_eff);
			burst_end = (64'(CHIPS) * 64'(cp_eff)) << 32;
			e.burst   = (64'(cyc) <= burst_end);
			if (chip >= 24'(CHIPS)) begin
				e.chip  = 4'(CHIPS);
				e.value = '0;
			end else begin
				prod   = int'(amp) * sine_tab[frac[31:22]];
				scaled = clamp16(prod >>> 15);
				if (CHIP_FLIP[chip]) begin
					scaled = clamp16(-scaled);
				end
				e.chip  = chip[3:0];
				e.value = 16'(scaled);
			end
			expected_q.push_back(e);
		endfunction

		function void check_sample(logic signed [15:0] value, logic [3:0] chip, logic burst);
			sample_t e;
			if (expected_q.size() == 0) begin
				$error("sample_out: unexpected sample value=%0d chip=%0d burst=%0d",
					value, chip, burst);
				failures++;
				return;
			end
			e = expected_q.pop_front();
			if (value !== e.value) begin
				$error("sample_value: expected %0d, actual %0d", e.value, value);
				failures++;
			end
			if (chip !== e.chip) begin
				$error("chip_number: expected %0d, actual %0d", e.chip, chip);
				failures++;
			end
			if (burst !== e.burst) begin
				$error("in_burst: expected %0d, actual %0d", e.burst, burst);
				failures++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	bit                   steady;
	int                   stall_cycles;
	sample_board          board;

	b13_in_if  sample_in ();
	b13_out_if sample_out ();

	barker13_bpsk_sample_generator_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.sample_in  (sample_in),
		.sample_out (sample_out)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			sample_out.ready <= steady || ($urandom_range(0, 99) >= 16);
		end
	end

	always @(posedge clk) begin
		if (arst_n && sample_out.valid && sample_out.ready) begin
			board.check_sample(sample_out.sample_value, sample_out.chip_number,
				sample_out.in_burst);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_in.valid && sample_in.ready) ||
				(sample_out.valid && sample_out.ready)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("** barker13_bpsk_sample_generator_top: FAILED **");
				$finish;
			end
		end
	end

	task automatic send_index(input logic [23:0] idx);
		while (!steady && $urandom_range(0, 99) < 16) begin
			sample_in.valid <= 1'b0;
			@(posedge clk);
		end
		sample_in.valid        <= 1'b1;
		sample_in.sample_index <= idx;
		@(posedge clk);
		while (!sample_in.ready) begin
			@(posedge clk);
		end
		board.note_index(idx);
	endtask

	// Hold the sender until every sample in flight has come back.
	task automatic drain();
		sample_in.valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic put_reg(input cfg_reg_e r, input logic [31:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v;
		@(posedge clk);
		board.set_reg(r, v);
	endtask

	task automatic write_config(input bit [2:0] which, input logic [31:0] step,
		input logic [15:0] periods, input logic [15:0] amp);
		drain();
		repeat (6) @(posedge clk);
		if (which[CFG_CARRIER_STEP]) begin
			put_reg(CFG_CARRIER_STEP, step);
		end
		if (which[CFG_CHIP_PERIODS]) begin
			put_reg(CFG_CHIP_PERIODS, {16'd0, periods});
		end
		if (which[CFG_AMPLITUDE]) begin
			put_reg(CFG_AMPLITUDE, {16'd0, amp});
		end
		cfg_we <= 1'b0;
	endtask

	// Bias indexes toward the burst and its end so most samples carry chips.
	function automatic logic [23:0] pick_index();
		longint span;
		longint cp_eff;
		longint idx;
		cp_eff = (board.periods == 16'd0) ? 1 : longint'(board.periods);
		if (board.step == 32'd0) begin
			span = 24'hFF_FFFF;
		end else begin
			span = ((13 * cp_eff) << 32) / longint'(board.step);
		end
		if (span > 24'hFF_FFFF) begin
			span = 24'hFF_FFFF;
		end
		case ($urandom_range(0, 9))
			0, 1: idx = longint'($urandom_range(0, 24'hFF_FFFF));
			2: begin
				idx = span + longint'($urandom_range(0, 4)) - 2;
			end
			default: begin
				idx = span + span / 8 + 1;
				if (idx > 24'hFF_FFFF) begin
					idx = 24'hFF_FFFF;
				end
				idx = longint'($urandom_range(0, 32'(idx)));
			end
		endcase
		if (idx < 0) begin
			idx = 0;
		end
		if (idx > 24'hFF_FFFF) begin
			idx = 24'hFF_FFFF;
		end
		return 24'(idx);
	endfunction

	function automatic logic [31:0] pick_step();
		case ($urandom_range(0, 6))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'hFFFF_FFFF;
			3: return $urandom_range(1, 32'h0001_0000);
			4: return $urandom_range(32'h0100_0000, 32'h4000_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_periods();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'hFFFF;
			3, 4: return 16'($urandom_range(1, 4));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_amp();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		board                  = new();
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = CFG_CARRIER_STEP;
		cfg_wdata              = '0;
		sample_in.valid        = 1'b0;
		sample_in.sample_index = '0;
		sample_out.ready       = 1'b0;
		steady                 = 1'b0;
		stall_cycles           = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: field extremes and the end of the burst.
		send_index(24'd0);
		send_index(24'd1);
		send_index(24'hFF_FFFF);
		send_index(24'h80_0000);
		send_index(24'h55_5555);
		send_index(24'hAA_AAAA);
		send_index(24'd129);
		send_index(24'd130);

		// Half a cycle per sample, zero chip length read as one: index 26 ends
		// exactly on the last chip boundary.
		write_config(3'b111, 32'h8000_0000, 16'd0, 16'h8000);
		send_index(24'd1);
		send_index(24'd25);
		send_index(24'd26);
		send_index(24'd27);

		// Quarter cycle per sample reaches the sine peaks at full negative scale.
		write_config(3'b011, 32'h4000_0000, 16'd1, 16'h0000);
		send_index(24'd1);
		send_index(24'd3);
		send_index(24'd21);
		send_index(24'd23);
		send_index(24'd52);
		send_index(24'd53);

		write_config(3'b100, 32'd0, 16'd0, 16'h7FFF);
		send_index(24'd1);
		send_index(24'd3);
		send_index(24'd5);

		for (int p = 0; p < 10; p++) begin
			case (p)
				0: write_config(3'b111, 32'hFFFF_FFFF, 16'hFFFF, 16'h7FFF);
				1: write_config(3'b111, 32'd1, 16'd1, 16'h8000);
				2: write_config(3'b111, 32'h1999_999A, 16'd2, 16'h4000);
				default: begin
					write_config(3'($urandom_range(1, 7)), pick_step(), pick_periods(),
						pick_amp());
				end
			endcase
			steady = (p == 3);
			for (int i = 0; i < RANDOM_ITEMS; i++) begin
				if (p == 5 && i == RANDOM_ITEMS / 2) begin
					drain();
				end
				send_index(pick_index());
			end
		end
		steady = 1'b0;

		drain();
		repeat (10) @(posedge clk);
		if (board.failures == 0 && board.pending() == 0) begin
			$display("** barker13_bpsk_sample_generator_top: PASSED **");
		end else begin
			$display("** barker13_bpsk_sample_generator_top: FAILED **");
		end
		$finish;
	end

endmodule

FILE: barker13_bpsk_sample_generator_top.f
+incdir+rtl/core
rtl/core/b13_pkg.sv
rtl/core/b13_if.sv
rtl/core/b13_phase.sv
rtl/core/b13_chip.sv
rtl/core/b13_sine.sv
rtl/core/b13_scale.sv
rtl/core/barker13_bpsk_sample_generator_top.sv
tb/sv/tb_barker13_bpsk_sample_generator_top.sv
